// ===== rtl/slrb_pkg.sv =====
package slrb_pkg;

    localparam int CHAR_BITS     = 9;
    localparam int DEPTH         = 128;
    localparam int PTR_BITS      = $clog2(DEPTH);
    localparam int CNT_BITS      = PTR_BITS;
    localparam int FILL_OUT_BITS = 7;
    localparam int ECHO_LIMIT    = 63;
    localparam int ECHO_BITS     = $clog2(ECHO_LIMIT + 1);
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);

    localparam logic [CHAR_BITS-1:0] TERM_RESET = CHAR_BITS'(13);

    // input mode codes
    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_DRAIN = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_ECHO   = 1'b1;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_DRAIN,
        OP_FLUSH,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic                 is_term;
        logic [CHAR_BITS-1:0] ch;
    } cmd_t;

endpackage

// ===== rtl/slrb_front.sv =====
module slrb_front
    import slrb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [CHAR_BITS-1:0] cfg_data,
    input  logic [1:0]           mode,
    input  logic [CHAR_BITS-1:0] rx_char,
    output cmd_t                 cmd
);

    logic [CHAR_BITS-1:0] term_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_reg <= TERM_RESET;
        end else if (cfg_valid) begin
            term_reg <= cfg_data;
        end
    end

    // classify the request; unused mode becomes a no-op
    always_comb begin
        cmd.ch      = rx_char;
        cmd.is_term = (rx_char == term_reg);
        unique case (mode)
            MODE_CHAR:  cmd.op = OP_CHAR;
            MODE_DRAIN: cmd.op = OP_DRAIN;
            MODE_FLUSH: cmd.op = OP_FLUSH;
            default:    cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== rtl/slrb_queue.sv =====
module slrb_queue
    import slrb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head_cmd
);

    cmd_t                slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_BITS:0]   count_reg, count_next;

    assign not_full  = (count_reg != (Q_PTR_BITS + 1)'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/slrb_back.sv =====
module slrb_back
    import slrb_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    input  cmd_t                     q_cmd,
    output logic                     q_pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_kind,
    output logic [CHAR_BITS-1:0]     out_char,
    output logic                     out_last,
    output logic                     out_full,
    output logic [FILL_OUT_BITS-1:0] out_fill
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ECHO = 1'b1;

    logic [CHAR_BITS-1:0] line_mem [DEPTH];

    logic                 state_reg, state_next;
    logic [PTR_BITS-1:0]  head_reg, head_next;
    logic [CNT_BITS-1:0]  fill_reg, fill_next;
    logic                 full_reg, full_next;
    logic [PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [ECHO_BITS-1:0] remain_reg, remain_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [CHAR_BITS-1:0] rd_data_reg;

    logic                     out_vld_reg, out_vld_next;
    logic                     out_kind_reg, out_kind_next;
    logic [CHAR_BITS-1:0]     out_char_reg, out_char_next;
    logic                     out_last_reg, out_last_next;
    logic                     out_full_reg, out_full_next;
    logic [FILL_OUT_BITS-1:0] out_fill_reg, out_fill_next;

    logic                out_free;
    logic                wr_en;
    logic [PTR_BITS-1:0] wr_addr;
    logic                issue;
    logic                move;
    logic                load_status;
    logic [CNT_BITS-1:0] take;

    assign out_free = !out_vld_reg || out_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;
    assign wr_addr  = PTR_BITS'(head_reg + fill_reg);
    assign take     = (fill_reg > CNT_BITS'(ECHO_LIMIT)) ? CNT_BITS'(ECHO_LIMIT) : fill_reg;
    assign move     = (state_reg == ST_ECHO) && rd_vld_reg && out_free;
    assign issue    = (state_reg == ST_ECHO) && (remain_reg != '0) && (!rd_vld_reg || move);

    always_comb begin
        state_next  = state_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        full_next   = full_reg;
        rd_ptr_next = rd_ptr_reg;
        remain_next = remain_reg;
        rd_vld_next = rd_vld_reg;
        wr_en       = 1'b0;
        load_status = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_cmd.op)
                        OP_CHAR: begin
                            load_status = 1'b1;
                            if (fill_reg < CNT_BITS'(DEPTH - 1) && !q_cmd.is_term
                                    && !full_reg) begin
                                wr_en     = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end else begin
                                full_next = 1'b1;
                            end
                        end
                        OP_DRAIN: begin
                            if (full_reg) begin
                                fill_next   = fill_reg - take;
                                full_next   = (fill_reg > CNT_BITS'(ECHO_LIMIT));
                                head_next   = head_reg + PTR_BITS'(take);
                                rd_ptr_next = head_reg;
                                remain_next = ECHO_BITS'(take);
                                if (take != '0) begin
                                    state_next = ST_ECHO;
                                end else begin
                                    load_status = 1'b1;
                                end
                            end else begin
                                load_status = 1'b1;
                            end
                        end
                        OP_FLUSH: begin
                            fill_next   = '0;
                            full_next   = 1'b0;
                            load_status = 1'b1;
                        end
                        default: begin
                            load_status = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                if (issue) begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                    rd_vld_next = 1'b1;
                end else if (move) begin
                    rd_vld_next = 1'b0;
                end
                if (remain_reg == '0 && !rd_vld_reg && out_free) begin
                    load_status = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
        endcase
    end

    // output register: echoes carry the post-drain state like the status does
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_kind_next = out_kind_reg;
        out_char_next = out_char_reg;
        out_last_next = out_last_reg;
        out_full_next = out_full_reg;
        out_fill_next = out_fill_reg;
        priority if (load_status) begin
            out_vld_next  = 1'b1;
            out_kind_next = KIND_STATUS;
            out_char_next = '0;
            out_last_next = 1'b1;
            out_full_next = full_next;
            out_fill_next = FILL_OUT_BITS'(fill_next);
        end else if (move) begin
            out_vld_next  = 1'b1;
            out_kind_next = KIND_ECHO;
            out_char_next = rd_data_reg;
            out_last_next = 1'b0;
            out_full_next = full_reg;
            out_fill_next = FILL_OUT_BITS'(fill_reg);
        end else if (out_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            fill_reg    <= '0;
            full_reg    <= 1'b0;
            remain_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            fill_reg    <= fill_next;
            full_reg    <= full_next;
            remain_reg  <= remain_next;
            rd_vld_reg  <= rd_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        out_kind_reg <= out_kind_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_full_reg <= out_full_next;
        out_fill_reg <= out_fill_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= q_cmd.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= line_mem[rd_ptr_reg];
        end
    end

    assign out_valid = out_vld_reg;
    assign out_kind  = out_kind_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign out_full  = out_full_reg;
    assign out_fill  = out_fill_reg;

endmodule

// ===== rtl/serial_line_receive_buffer.sv =====
// Line buffer for received serial characters, closed by a terminator.
// Input stream (s_): each transfer is one request. s_tuser selects it:
// store a received character (s_tdata), drain the line by echo, or flush.
// Output stream (m_): echoed characters (m_tuser = 1) followed by exactly
// one status transfer per request (m_tuser = 0, m_tlast = 1). Every result
// carries the full flag and fill count as they stand after the request.
// Config channel (cfg_): writes the terminator; write only while idle.
// Path: a request waits in the command queue, then its result is registered
// in the output register; echoes first pass the read data register. Plain
// requests sustain one per cycle while m_tready is high; a drain of a closed
// line (N at most 63 characters per request) holds the back until its status,
// one echo per cycle while m_tready is high, through the single read port of the line memory.
// A four-entry command queue parts the front from the back, so s_tready
// only drops when that queue fills, e.g. while a long drain or a stalled
// m_tready holds the back. Stalls on m_ hold the output register.
// Reset: empty line, flag clear, terminator 13; no clearing pass is needed.
module serial_line_receive_buffer
    import slrb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // terminator write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    // requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [8:0] rx_char, rest zero
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [8:0] out_char, [9] full_flag, [16:10] fill_count
    output logic [0:0]  m_tuser,   // [0] kind
    output logic        m_tlast    // is_last
);

    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_not_full;
    logic q_not_empty;
    logic q_pop;
    logic push;

    logic                     out_kind;
    logic [CHAR_BITS-1:0]     out_char;
    logic                     out_full;
    logic [FILL_OUT_BITS-1:0] out_fill;

    // terminator can always be taken
    assign cfg_ready = 1'b1;
    assign s_tready  = q_not_full;
    assign push      = s_tvalid && q_not_full;

    slrb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data[CHAR_BITS-1:0]),
        .mode     (s_tuser),
        .rx_char  (s_tdata[CHAR_BITS-1:0]),
        .cmd      (front_cmd)
    );

    // hold classified requests until the back is free
    slrb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (front_cmd),
        .not_full (q_not_full),
        .pop      (q_pop),
        .not_empty(q_not_empty),
        .head_cmd (head_cmd)
    );

    // line memory, fill state and output register
    slrb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_kind (out_kind),
        .out_char (out_char),
        .out_last (m_tlast),
        .out_full (out_full),
        .out_fill (out_fill)
    );

    // pack result fields, lowest first, padded to whole bytes
    assign m_tdata = {7'd0, out_fill, out_full, out_char};
    assign m_tuser = out_kind;

endmodule
